>>> rtl/chte_pkg.sv
// Package for the chained hash table engine: operation and status codes,
// sequencer state type and default sizes. No dependencies.
package chte_pkg;

	localparam int unsigned BucketsDefault = 64;
	localparam int unsigned EntriesDefault = 256;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FOUND    = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_SLOT_RD,
		S_SLOT_WAIT,
		S_CMP,
		S_ALLOC,
		S_FREE_RD,
		S_FREE_WAIT,
		S_WRITE,
		S_DONE
	} seq_state_t;

endpackage

>>> rtl/chained_hash_table_engine.sv
// Top level of the chained hash table engine: sequencer, bucket head memory,
// slot memories and free list. Depends on chte_pkg and chte_ram.
//
//  channel   signals                      direction  handshake
//  request   start, kind, key, value      in         start & !busy
//  result    done, status, found_value,   out        done, one cycle
//            entry_count
//
// After acceptance S_HEAD_RD reduces the key to its bucket and reads the bucket
// head. Each chain link compared then passes through S_SLOT_RD, S_SLOT_WAIT and
// S_CMP, because the slot memories have a single port and a registered read. A
// request that finds its key goes on to S_WRITE, one that misses and changes
// nothing to S_ALLOC; a new key goes through S_ALLOC and S_WRITE, and through
// S_FREE_RD and S_FREE_WAIT as well when its slot comes from the free list.
// After reset a clearing pass writes the null marker into every bucket head,
// one per cycle; busy is high during it.
// The receiver cannot stall: done pulses for one cycle and busy falls with it.
module chained_hash_table_engine
	import chte_pkg::*;
#(
	parameter int unsigned BUCKETS = BucketsDefault,
	parameter int unsigned ENTRIES = EntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] found_value,
	output logic [8:0]  entry_count
);
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned SW = $clog2(ENTRIES) + 1; // slot index plus null
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam logic [SW-1:0] NIL = SW'(ENTRIES);
	localparam logic [31:0] BUCKETS32 = 32'(BUCKETS);
	// Truncated reciprocal of BUCKETS; the quotient it gives is low by at most one.
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);

	seq_state_t state_q, state_d;

	logic [1:0]    kind_q;
	logic [31:0]   key_q, value_q;
	logic [31:0]   quo_q;              // estimated quotient of key by BUCKETS
	logic [31:0]   rem_q;              // key minus estimate, below twice BUCKETS
	logic [BW-1:0] bucket_q;
	logic [BW-1:0] clr_q;
	logic          clr_busy_q;
	logic [SW-1:0] cur_q, pred_q, nxt_q;
	logic [SW-1:0] steps_q;
	logic [SW-1:0] free_head_q, never_q, held_q;
	logic [SW-1:0] new_slot_q;
	logic [2:0]    status_q;
	logic [31:0]   fv_q;
	logic [1:0]    wr_phase_q;
	logic [1:0]    red_q;

	// Memory ports.
	logic          head_we, slot_we_key, slot_we_val, slot_we_next;
	logic [BW-1:0] head_addr;
	logic [SW-1:0] head_wdata, head_rdata;
	logic [AW-1:0] slot_addr;
	logic [31:0]   key_rdata, val_rdata, key_wdata, val_wdata;
	logic [SW-1:0] next_wdata, next_rdata;

	chte_ram #(.Width(SW), .Depth(BUCKETS)) u_head (
		.clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wdata), .rdata(head_rdata));
	chte_ram #(.Width(32), .Depth(ENTRIES)) u_key (
		.clk(clk), .we(slot_we_key), .addr(slot_addr), .wdata(key_wdata), .rdata(key_rdata));
	chte_ram #(.Width(32), .Depth(ENTRIES)) u_val (
		.clk(clk), .we(slot_we_val), .addr(slot_addr), .wdata(val_wdata), .rdata(val_rdata));
	chte_ram #(.Width(SW), .Depth(ENTRIES)) u_next (
		.clk(clk), .we(slot_we_next), .addr(slot_addr), .wdata(next_wdata),
		.rdata(next_rdata));

	// A stored next pointer above the null marker is read as null.
	logic [SW-1:0] next_clean;
	assign next_clean = (next_rdata > NIL) ? NIL : next_rdata;

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE) || clr_busy_q;

	// The bucket is found in S_HEAD_RD in steps counted by red_q: a
	// reciprocal multiply estimates the quotient, the remainder follows from it,
	// one compare and subtract corrects it, and the last step reads the head.
	logic [63:0] prod;
	logic [31:0] qb;
	assign prod = 64'(key_q) * 64'(RECIP);
	assign qb   = quo_q * BUCKETS32;

	logic key_hit;
	assign key_hit = (key_rdata == key_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (accept) state_d = S_HEAD_RD;
			S_HEAD_RD:   if (red_q == 2'd3) state_d = S_HEAD_WAIT;
			S_HEAD_WAIT: state_d = S_SLOT_RD;
			S_SLOT_RD: begin
				if (cur_q >= NIL || steps_q >= NIL) state_d = S_ALLOC;
				else state_d = S_SLOT_WAIT;
			end
			S_SLOT_WAIT: state_d = S_CMP;
			S_CMP:       state_d = key_hit ? S_WRITE : S_SLOT_RD;
			S_ALLOC: begin
				if (kind_q != KIND_INSERT || held_q >= NIL) state_d = S_DONE;
				else if (free_head_q < NIL) state_d = S_FREE_RD;
				else if (never_q < NIL) state_d = S_WRITE;
				else state_d = S_DONE;
			end
			S_FREE_RD:   state_d = S_FREE_WAIT;
			S_FREE_WAIT: state_d = S_WRITE;
			S_WRITE:     if (wr_phase_q == 2'd1) state_d = S_DONE;
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory control. Apart from the clearing pass, writes happen in S_WRITE:
	// phase 0 may touch the slot, phase 1 a predecessor slot or the bucket head.
	logic found_q;
	always_comb begin
		head_we      = 1'b0;
		head_addr    = bucket_q;
		head_wdata   = NIL;
		slot_we_key  = 1'b0;
		slot_we_val  = 1'b0;
		slot_we_next = 1'b0;
		slot_addr    = cur_q[AW-1:0];
		key_wdata    = key_q;
		val_wdata    = value_q;
		next_wdata   = NIL;
		if (clr_busy_q) begin
			head_we   = 1'b1;
			head_addr = clr_q;
		end
		case (state_q)
			S_FREE_RD: slot_addr = free_head_q[AW-1:0];
			S_WRITE: begin
				if (found_q) begin
					if (kind_q == KIND_INSERT) begin
						slot_we_val = (wr_phase_q == 2'd0);
					end else if (kind_q == KIND_REMOVE) begin
						if (wr_phase_q == 2'd0) begin
							slot_we_next = 1'b1;
							next_wdata   = free_head_q;
						end else if (pred_q >= NIL) begin
							head_we    = 1'b1;
							head_wdata = nxt_q;
						end else begin
							slot_we_next = 1'b1;
							slot_addr    = pred_q[AW-1:0];
							next_wdata   = nxt_q;
						end
					end
				end else begin
					slot_addr = new_slot_q[AW-1:0];
					if (wr_phase_q == 2'd0) begin
						slot_we_key  = 1'b1;
						slot_we_val  = 1'b1;
						slot_we_next = 1'b1;
						next_wdata   = head_rdata;
					end else begin
						head_we    = 1'b1;
						head_wdata = new_slot_q;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_busy_q  <= 1'b1;
			clr_q       <= '0;
			free_head_q <= NIL;
			never_q     <= '0;
			held_q      <= '0;
			done        <= 1'b0;
			wr_phase_q  <= '0;
			red_q       <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == S_DONE);
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == BW'(BUCKETS - 1)) clr_busy_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (accept) begin
					red_q      <= '0;
					found_q    <= 1'b0;
					wr_phase_q <= '0;
				end
				S_HEAD_RD: red_q <= red_q + 1'b1;
				S_CMP: if (key_hit) found_q <= 1'b1;
				S_ALLOC: if (kind_q == KIND_INSERT && held_q < NIL &&
					free_head_q >= NIL && never_q < NIL) begin
					never_q <= never_q + 1'b1;
				end
				S_FREE_WAIT: free_head_q <= next_clean;
				S_WRITE: begin
					wr_phase_q <= wr_phase_q + 1'b1;
					if (wr_phase_q == 2'd1) begin
						if (!found_q) held_q <= held_q + 1'b1;
						else if (kind_q == KIND_REMOVE) begin
							free_head_q <= cur_q;
							if (held_q != '0) held_q <= held_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				kind_q  <= (kind == KIND_INSERT || kind == KIND_REMOVE) ? kind : KIND_LOOKUP;
				key_q   <= key;
				value_q <= value;
				fv_q    <= '0;
				steps_q <= '0;
				pred_q  <= NIL;
			end
			S_HEAD_RD: begin
				if (red_q == 2'd0) quo_q <= prod[63:32];
				if (red_q == 2'd1) rem_q <= key_q - qb;
				if (red_q == 2'd2) begin
					bucket_q <= (rem_q >= BUCKETS32) ? BW'(rem_q - BUCKETS32) : BW'(rem_q);
				end
			end
			S_HEAD_WAIT: cur_q <= head_rdata;
			S_SLOT_RD: begin
				if (cur_q >= NIL || steps_q >= NIL) begin
					cur_q <= NIL;
					pred_q <= NIL;
				end
			end
			S_CMP: begin
				nxt_q <= next_clean;
				if (key_hit) begin
					fv_q <= val_rdata;
				end else begin
					pred_q  <= cur_q;
					cur_q   <= next_clean;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_ALLOC: begin
				if (kind_q == KIND_INSERT && held_q >= NIL) status_q <= ST_FULL;
				else if (kind_q == KIND_INSERT && free_head_q >= NIL && never_q >= NIL)
					status_q <= ST_FULL;
				else if (kind_q == KIND_INSERT) status_q <= ST_INSERTED;
				else status_q <= ST_NOTFOUND;
				if (free_head_q < NIL) new_slot_q <= free_head_q;
				else new_slot_q <= never_q;
				fv_q <= '0;
			end
			S_WRITE: begin
				if (found_q) begin
					if (kind_q == KIND_INSERT) begin
						status_q <= ST_REPLACED;
						fv_q <= '0;
					end else if (kind_q == KIND_REMOVE) begin
						status_q <= ST_REMOVED;
						fv_q <= '0;
					end else begin
						status_q <= ST_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	assign status      = status_q;
	assign found_value = fv_q;
	assign entry_count = 9'(held_q);

endmodule

>>> rtl/chte_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module chte_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> bench/chained_hash_table_engine_tb.sv
// Self-checking testbench for chained_hash_table_engine: inserts, removes and lookups
// checked against a behavioral copy of the hash table. Depends on chte_pkg and the RTL.
`timescale 1ns / 1ps

module chained_hash_table_engine_tb;
	import chte_pkg::*;

	localparam int unsigned NB = BucketsDefault;
	localparam int unsigned NE = EntriesDefault;
	localparam int unsigned NULL_SLOT = NE;
	// The spare kind code behaves as a lookup.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [31:0] value;
		bit          hold; // wait for the table to drain before this request
	} op_req_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] found_value;
		logic [8:0]  entry_count;
	} op_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [31:0] key;
	logic [31:0] value;
	logic        done;
	logic [2:0]  status;
	logic [31:0] found_value;
	logic [8:0]  entry_count;

	chained_hash_table_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .key(key), .value(value), .done(done), .status(status),
		.found_value(found_value), .entry_count(entry_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Shadow copy of the table; a slot is only ever linked after it was written.
	int unsigned  head_of[NB];
	logic [31:0]  key_of[NE];
	logic [31:0]  val_of[NE];
	int unsigned  link_of[NE];
	int unsigned  free_top;
	int unsigned  fresh_slots;
	int unsigned  held;

	op_req_t pending_q[$];
	op_rsp_t awaited_q[$];
	int      errors;
	int      n_sent;
	int      n_full;
	int      n_walk_max;
	int      gap_left;
	bit      gaps_on;

	task automatic report(input string what);
		errors++;
		$display("%0t ERROR %s", $realtime, what);
	endtask

	// Applies one request to the shadow table and returns the answer it should give.
	function automatic op_rsp_t apply_op(input op_req_t r);
		op_rsp_t     a;
		int unsigned b, s, prev, n, steps;
		a.found_value = '0;
		b = r.key % NB;
		s = head_of[b];
		prev = NULL_SLOT;
		steps = 0;
		while (s < NE && steps < NE && key_of[s] != r.key) begin
			prev = s;
			s = link_of[s];
			steps++;
		end
		if (steps > n_walk_max) n_walk_max = steps;
		if (steps >= NE) s = NULL_SLOT;
		if (r.kind == KIND_INSERT) begin
			if (s != NULL_SLOT) begin
				val_of[s] = r.value;
				a.status = ST_REPLACED;
			end else if (held >= NE) begin
				a.status = ST_FULL;
			end else begin
				if (free_top < NE) begin
					n = free_top;
					free_top = link_of[n];
				end else begin
					n = fresh_slots;
					fresh_slots++;
				end
				key_of[n] = r.key;
				val_of[n] = r.value;
				link_of[n] = head_of[b];
				head_of[b] = n;
				held++;
				a.status = ST_INSERTED;
			end
		end else if (r.kind == KIND_REMOVE) begin
			if (s == NULL_SLOT) begin
				a.status = ST_NOTFOUND;
			end else begin
				if (prev == NULL_SLOT) head_of[b] = link_of[s];
				else link_of[prev] = link_of[s];
				link_of[s] = free_top;
				free_top = s;
				held--;
				a.status = ST_REMOVED;
			end
		end else begin
			if (s == NULL_SLOT) begin
				a.status = ST_NOTFOUND;
			end else begin
				a.status = ST_FOUND;
				a.found_value = val_of[s];
			end
		end
		a.entry_count = held[8:0];
		return a;
	endfunction

	// Driver: holds start until the request is taken, then sends the next queued
	// request back to back, idles for a random gap, or waits for results on a held one.
	always @(posedge clk or negedge arst_n) begin
		op_req_t r;
		bit      taken;
		bit      drive_next;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_INSERT;
			key <= '0;
			value <= '0;
			gap_left = 0;
		end else begin
			taken = start && !busy;
			drive_next = 1'b0;
			if (taken) begin
				r.kind = kind;
				r.key = key;
				r.value = value;
				awaited_q.push_back(apply_op(r));
				n_sent++;
				if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					if (!pending_q[0].hold || (awaited_q.size() == 0 && !taken))
						drive_next = 1'b1;
				end
				if (drive_next) begin
					r = pending_q.pop_front();
					kind <= r.kind;
					key <= r.key;
					value <= r.value;
				end
				start <= drive_next;
			end
		end
	end

	// Monitor: every done pulse is one result, checked against the oldest expectation.
	always @(posedge clk) begin
		op_rsp_t e;
		if (arst_n && done) begin
			if (awaited_q.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				e = awaited_q.pop_front();
				if (e.status == ST_FULL) n_full++;
				if (status !== e.status)
					report($sformatf("status %0d, expected %0d", status, e.status));
				if (found_value !== e.found_value)
					report($sformatf("found_value %h, expected %h", found_value,
						e.found_value));
				if (entry_count !== e.entry_count)
					report($sformatf("entry_count %0d, expected %0d", entry_count,
						e.entry_count));
			end
		end
	end

	function automatic op_req_t mk(input logic [1:0] k, input logic [31:0] ky,
		input logic [31:0] v, input bit h = 1'b0);
		op_req_t r;
		r.kind = k;
		r.key = ky;
		r.value = v;
		r.hold = h;
		return r;
	endfunction

	logic [31:0] hot_keys[48];

	// Most keys come from a small set that crowds a few buckets, so chains grow.
	function automatic logic [31:0] pick_key();
		int unsigned c;
		c = $urandom_range(0, 9);
		if (c < 7) return hot_keys[$urandom_range(0, 47)];
		if (c == 7) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_kind();
		int unsigned c;
		c = $urandom_range(0, 9);
		if (c < 4) return KIND_INSERT;
		if (c < 7) return KIND_REMOVE;
		if (c < 9) return KIND_LOOKUP;
		return KIND_SPARE;
	endfunction

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		errors = 0;
		n_sent = 0;
		n_full = 0;
		n_walk_max = 0;
		gaps_on = 1'b1;
		for (i = 0; i < NB; i++) head_of[i] = NULL_SLOT;
		free_top = NULL_SLOT;
		fresh_slots = 0;
		held = 0;
		for (i = 0; i < 48; i++) hot_keys[i] = {$urandom} & ~32'h3F | (i % 6);

		// Directed: extremes, one bucket chain of three, removal in the middle, at the
		// head and of a lone entry, misses, replace, the spare kind code and free slot reuse.
		pending_q.push_back(mk(KIND_LOOKUP, 32'h0, 32'h0));
		pending_q.push_back(mk(KIND_INSERT, 32'h0, 32'h0));
		pending_q.push_back(mk(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_q.push_back(mk(KIND_INSERT, 32'h40, 32'hA5A5_5A5A));
		pending_q.push_back(mk(KIND_INSERT, 32'h80, 32'h5A5A_A5A5));
		pending_q.push_back(mk(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF));
		pending_q.push_back(mk(KIND_SPARE, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(KIND_INSERT, 32'h40, 32'hFFFF_FFFF));
		pending_q.push_back(mk(KIND_LOOKUP, 32'h40, 32'h0));
		pending_q.push_back(mk(KIND_REMOVE, 32'h40, 32'h0));
		pending_q.push_back(mk(KIND_REMOVE, 32'h40, 32'h0));
		pending_q.push_back(mk(KIND_LOOKUP, 32'hC0, 32'h0));
		pending_q.push_back(mk(KIND_REMOVE, 32'h80, 32'h0));
		pending_q.push_back(mk(KIND_REMOVE, 32'h0, 32'h0));
		pending_q.push_back(mk(KIND_INSERT, 32'h7FFF_FFC0, 32'h1234_5678, 1'b1));
		pending_q.push_back(mk(KIND_INSERT, 32'h8000_0000, 32'h8765_4321));
		pending_q.push_back(mk(KIND_LOOKUP, 32'h7FFF_FFC0, 32'h0));
		pending_q.push_back(mk(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(KIND_SPARE, 32'h8000_0000, 32'h0));

		// Random mix over crowded buckets.
		for (i = 0; i < 300; i++)
			pending_q.push_back(mk(pick_kind(), pick_key(), $urandom,
				$urandom_range(0, 59) == 0));
		// Fill the pool past its limit with distinct keys so inserts are refused.
		for (i = 0; i < 280; i++)
			pending_q.push_back(mk(KIND_INSERT, 32'h1000_0000 + i * 7, $urandom));
		// Churn on a full table, removing part of the filled keys along the way.
		for (i = 0; i < 60; i++) begin
			if ($urandom_range(0, 1))
				pending_q.push_back(mk(KIND_REMOVE, 32'h1000_0000 +
					$urandom_range(0, 279) * 7, 32'h0));
			else
				pending_q.push_back(mk(pick_kind(), pick_key(), $urandom));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Alternate between gappy and back-to-back stretches until all is sent.
		while (pending_q.size() > 0 || start) begin
			repeat (200) @(posedge clk);
			gaps_on = !gaps_on;
		end
		while (awaited_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (awaited_q.size() > 0) report("results still outstanding at the end");
		$display("Ran %0d requests; %0d refused on a full pool; longest chain walk %0d links.",
			n_sent, n_full, n_walk_max);
		if (errors == 0) begin
			$display("chained_hash_table_engine_tb passed");
		end else begin
			$display("chained_hash_table_engine_tb failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("chained_hash_table_engine_tb failed");
		$finish;
	end

endmodule
